FILE: sv/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants of the battery level monitor
// Field widths, register indexes, level codes, reset values and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

  // adc full scale is a power of two, the scaled value is a right shift
  localparam int ADC_SCALE_BITS = 12;
  localparam int ADC_FULL_SCALE = 2 ** ADC_SCALE_BITS;
  localparam logic [15:0] CURRENT_SCALE = 16'd1000;

  localparam int SAMPLE_W = 12;
  localparam int PHASE_W  = 10;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = 8;
  localparam int VAL_W    = 16;
  localparam int LVL_W    = 3;
  localparam int LED_W    = 4;
  localparam int PROD_W   = SUM_W + VAL_W;
  localparam int STEP_W   = $clog2(SUM_W);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL4_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL3_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_THR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_THR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE = 3'd7;

  // configuration reset values
  localparam logic [CNT_W-1:0] RST_SAMPLE_COUNT = 8'd10;
  localparam logic [VAL_W-1:0] RST_LEVEL4_THR   = 16'd1200;
  localparam logic [VAL_W-1:0] RST_LEVEL3_THR   = 16'd1140;
  localparam logic [VAL_W-1:0] RST_LEVEL2_THR   = 16'd1080;
  localparam logic [VAL_W-1:0] RST_LEVEL1_THR   = 16'd1020;
  localparam logic [VAL_W-1:0] RST_WARNING_THR  = 16'd960;
  localparam logic [VAL_W-1:0] RST_HYSTERESIS   = 16'd20;

  // battery level codes
  localparam logic [LVL_W-1:0] LVL_SHUTDOWN = 3'd0;
  localparam logic [LVL_W-1:0] LVL_WARNING  = 3'd1;
  localparam logic [LVL_W-1:0] LVL_ONE      = 3'd2;
  localparam logic [LVL_W-1:0] LVL_TWO      = 3'd3;
  localparam logic [LVL_W-1:0] LVL_THREE    = 3'd4;
  localparam logic [LVL_W-1:0] LVL_FOUR     = 3'd5;
  localparam logic [LVL_W-1:0] LVL_NONE     = 3'd7;

  // blink bounds in milliseconds
  localparam logic [PHASE_W-1:0] WARN_BLINK_MS = 10'd500;
  localparam logic [PHASE_W-1:0] SHUT_BLINK_MS = 10'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_UPD
  } state_e;

endpackage

`default_nettype wire

FILE: sv/battery_level_monitor.sv
// ----------------------------------------------------------------------------
// battery_level_monitor: averaged battery gauge with hysteretic level
// Sums voltage and current samples, scales the averages at the end of each
// window and steps a six-level battery state that drives LEDs, buzzer and
// bus power.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          voltage_sample, current_sample, ms_phase
//  m_axis    out  tvalid/tready          voltage, current, new_reading, level,
//                                        led_mask, buzzer_on, bus_power_on
//  cfg       in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  an item that does not close a window passes accept, sum and update
//  an item that closes a window runs divide, multiply and saturate for each
//  of the two averages in turn: one shared restoring divider forms both,
//  one shared multiplier scales both
//  one request is in work at a time; s_axis_tready is high only while idle
//  a held result stalls the final update until m_axis_tready takes it
//  rst_ni clears all control and state registers at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_monitor (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // voltage_sample[11:0], current_sample[23:12], ms_phase[33:24], zeros
  input  wire logic [blm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // voltage_value[15:0], current_value[31:16], new_reading[32],
  // battery_level[35:33], led_mask[39:36], buzzer_on[40], bus_power_on[41], zeros
  output      logic [blm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we_i,
  input  wire logic [blm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [blm_pkg::VAL_W-1:0]           cfg_wdata_i
);

  localparam int SW = blm_pkg::SUM_W;
  localparam int VW = blm_pkg::VAL_W;
  localparam int CW = blm_pkg::CNT_W;
  localparam int PW = blm_pkg::PROD_W;
  localparam int LW = blm_pkg::LVL_W;
  localparam int HW = VW + 2;

  // configuration
  logic [CW-1:0] cnt_cfg_q;
  logic [VW-1:0] l4_thr_q, l3_thr_q, l2_thr_q, l1_thr_q, warn_thr_q, hyst_q, vscale_q;

  // sequencer and state
  blm_pkg::state_e state_q, state_d;
  logic [CW-1:0]   counter_q, counter_d;
  logic [SW-1:0]   vsum_q, vsum_d, isum_q, isum_d;
  logic [VW-1:0]   volt_q, volt_d, curr_q, curr_d;
  logic [LW-1:0]   level_q, level_d, shown_q, shown_d;
  logic [blm_pkg::LED_W-1:0] led_q, led_d;
  logic            buzz_q, buzz_d, power_q, power_d, blink_q, blink_d;
  logic            win_q, win_d, sel_q, sel_d, ovalid_q, ovalid_d;

  // payload registers
  logic [blm_pkg::SAMPLE_W-1:0] vin_q, iin_q;
  logic [blm_pkg::PHASE_W-1:0]  phase_q;
  logic [CW-1:0]                div_q, div_d;
  logic [CW-1:0]                rem_q, rem_d;
  logic [SW-1:0]                quo_q, quo_d;
  logic [blm_pkg::STEP_W-1:0]   step_q, step_d;
  logic [PW-1:0]                prod_q;
  logic [blm_pkg::OUT_DATA_W-1:0] odata_q, odata_d;

  logic          accept, publish;
  logic [CW-1:0] count_eff, counter_inc;
  logic [SW-1:0] vsum_inc, isum_inc;
  logic [CW:0]   trial;
  logic [VW-1:0] mul_b, scaled;
  logic [HW-1:0] up4, up3, up2, up1, up0;
  logic [LW-1:0] lv_new;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == blm_pkg::ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign publish       = (state_q == blm_pkg::ST_UPD) && (!ovalid_q || m_axis_tready);

  assign count_eff   = (cnt_cfg_q == '0) ? CW'(1) : cnt_cfg_q;
  assign counter_inc = counter_q + CW'(1);
  assign vsum_inc    = vsum_q + SW'(vin_q);
  assign isum_inc    = isum_q + SW'(iin_q);

  // one restoring divide step per cycle
  assign trial = {rem_q, quo_q[SW-1]};

  // shared multiplier operand and saturation of the scaled average
  assign mul_b = sel_q ? blm_pkg::CURRENT_SCALE : vscale_q;
  assign scaled = (|prod_q[PW-1:VW+blm_pkg::ADC_SCALE_BITS]) ? '1 :
                  prod_q[VW+blm_pkg::ADC_SCALE_BITS-1:blm_pkg::ADC_SCALE_BITS];

  // rising thresholds, 18 bits so they never wrap
  assign up4 = HW'(l4_thr_q) + HW'(hyst_q);
  assign up3 = HW'(l3_thr_q) + HW'(hyst_q);
  assign up2 = HW'(l2_thr_q) + HW'(hyst_q);
  assign up1 = HW'(l1_thr_q) + HW'(hyst_q);
  assign up0 = HW'(warn_thr_q) + {1'b0, hyst_q, 1'b0} + HW'(hyst_q);

  always_comb begin
    lv_new = level_q;
    unique case (level_q)
      blm_pkg::LVL_FOUR: begin
        if (volt_q < l4_thr_q) lv_new = blm_pkg::LVL_THREE;
      end
      blm_pkg::LVL_THREE: begin
        if (volt_q < l3_thr_q) lv_new = blm_pkg::LVL_TWO;
        if (HW'(volt_q) >= up4) lv_new = blm_pkg::LVL_FOUR;
      end
      blm_pkg::LVL_TWO: begin
        if (volt_q < l2_thr_q) lv_new = blm_pkg::LVL_ONE;
        if (HW'(volt_q) >= up3) lv_new = blm_pkg::LVL_THREE;
      end
      blm_pkg::LVL_ONE: begin
        if (volt_q < l1_thr_q) lv_new = blm_pkg::LVL_WARNING;
        if (HW'(volt_q) >= up2) lv_new = blm_pkg::LVL_TWO;
      end
      blm_pkg::LVL_WARNING: begin
        if (volt_q < warn_thr_q) lv_new = blm_pkg::LVL_SHUTDOWN;
        if (HW'(volt_q) >= up1) lv_new = blm_pkg::LVL_ONE;
      end
      blm_pkg::LVL_SHUTDOWN: begin
        if (HW'(volt_q) >= up0) lv_new = blm_pkg::LVL_WARNING;
      end
      default: lv_new = level_q;
    endcase
  end

  // sequencer, accumulation and display
  always_comb begin
    state_d   = state_q;
    counter_d = counter_q;
    vsum_d    = vsum_q;
    isum_d    = isum_q;
    volt_d    = volt_q;
    curr_d    = curr_q;
    level_d   = level_q;
    shown_d   = shown_q;
    led_d     = led_q;
    buzz_d    = buzz_q;
    power_d   = power_q;
    blink_d   = blink_q;
    win_d     = win_q;
    sel_d     = sel_q;
    ovalid_d  = ovalid_q;
    div_d     = div_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    odata_d   = odata_q;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      blm_pkg::ST_IDLE: begin
        if (accept) state_d = blm_pkg::ST_ACC;
      end
      blm_pkg::ST_ACC: begin
        vsum_d    = vsum_inc;
        isum_d    = isum_inc;
        counter_d = counter_inc;
        win_d     = (counter_inc >= count_eff);
        if (counter_inc >= count_eff) begin
          div_d   = count_eff;
          rem_d   = '0;
          quo_d   = vsum_inc;
          step_d  = '0;
          sel_d   = 1'b0;
          state_d = blm_pkg::ST_DIV;
        end else begin
          state_d = blm_pkg::ST_UPD;
        end
      end
      blm_pkg::ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = CW'(trial - {1'b0, div_q});
          quo_d = {quo_q[SW-2:0], 1'b1};
        end else begin
          rem_d = trial[CW-1:0];
          quo_d = {quo_q[SW-2:0], 1'b0};
        end
        step_d = step_q + blm_pkg::STEP_W'(1);
        if (step_q == blm_pkg::STEP_W'(SW - 1)) state_d = blm_pkg::ST_MUL;
      end
      blm_pkg::ST_MUL: begin
        state_d = blm_pkg::ST_SAT;
      end
      blm_pkg::ST_SAT: begin
        if (sel_q) begin
          curr_d  = scaled;
          state_d = blm_pkg::ST_UPD;
        end else begin
          volt_d  = scaled;
          rem_d   = '0;
          quo_d   = isum_q;
          step_d  = '0;
          sel_d   = 1'b1;
          state_d = blm_pkg::ST_DIV;
        end
      end
      blm_pkg::ST_UPD: begin
        if (publish) begin
          if (win_q) begin
            counter_d = '0;
            vsum_d    = '0;
            isum_d    = '0;
          end
          level_d = lv_new;
          if (lv_new != shown_q) begin
            unique case (lv_new)
              blm_pkg::LVL_FOUR: begin
                led_d = 4'b1111; buzz_d = 1'b0; power_d = 1'b1;
              end
              blm_pkg::LVL_THREE: begin
                led_d = 4'b0111; buzz_d = 1'b0; power_d = 1'b1;
              end
              blm_pkg::LVL_TWO: begin
                led_d = 4'b0011; buzz_d = 1'b0; power_d = 1'b1;
              end
              blm_pkg::LVL_ONE: begin
                led_d = 4'b0001; buzz_d = 1'b0; power_d = 1'b1;
              end
              blm_pkg::LVL_WARNING: begin
                led_d = led_q & 4'b0001; power_d = 1'b1;
              end
              blm_pkg::LVL_SHUTDOWN: begin
                led_d = led_q & 4'b0001; buzz_d = 1'b0; power_d = 1'b0;
              end
              default: ;
            endcase
            shown_d = lv_new;
          end
          // warning blinks led1 and buzzer, shutdown blinks led1 only
          if (lv_new == blm_pkg::LVL_WARNING) begin
            if (phase_q < blm_pkg::WARN_BLINK_MS && !blink_q) begin
              led_d[0] = 1'b1; buzz_d = 1'b1; blink_d = 1'b1;
            end
            if (phase_q >= blm_pkg::WARN_BLINK_MS && blink_q) begin
              led_d[0] = 1'b0; buzz_d = 1'b0; blink_d = 1'b0;
            end
          end
          if (lv_new == blm_pkg::LVL_SHUTDOWN) begin
            if (phase_q < blm_pkg::SHUT_BLINK_MS && !blink_q) begin
              led_d[0] = 1'b1; blink_d = 1'b1;
            end
            if (phase_q >= blm_pkg::SHUT_BLINK_MS && blink_q) begin
              led_d[0] = 1'b0; blink_d = 1'b0;
            end
          end
          odata_d = {6'b0, power_d, buzz_d, led_d, lv_new, win_q, curr_q, volt_q};
          ovalid_d = 1'b1;
          state_d  = blm_pkg::ST_IDLE;
        end
      end
      default: state_d = blm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= blm_pkg::ST_IDLE;
      counter_q <= '0;
      vsum_q    <= '0;
      isum_q    <= '0;
      volt_q    <= '0;
      curr_q    <= '0;
      level_q   <= blm_pkg::LVL_FOUR;
      shown_q   <= blm_pkg::LVL_NONE;
      led_q     <= '0;
      buzz_q    <= 1'b0;
      power_q   <= 1'b1;
      blink_q   <= 1'b0;
      win_q     <= 1'b0;
      sel_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      vsum_q    <= vsum_d;
      isum_q    <= isum_d;
      volt_q    <= volt_d;
      curr_q    <= curr_d;
      level_q   <= level_d;
      shown_q   <= shown_d;
      led_q     <= led_d;
      buzz_q    <= buzz_d;
      power_q   <= power_d;
      blink_q   <= blink_d;
      win_q     <= win_d;
      sel_q     <= sel_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q  <= blm_pkg::RST_SAMPLE_COUNT;
      l4_thr_q   <= blm_pkg::RST_LEVEL4_THR;
      l3_thr_q   <= blm_pkg::RST_LEVEL3_THR;
      l2_thr_q   <= blm_pkg::RST_LEVEL2_THR;
      l1_thr_q   <= blm_pkg::RST_LEVEL1_THR;
      warn_thr_q <= blm_pkg::RST_WARNING_THR;
      hyst_q     <= blm_pkg::RST_HYSTERESIS;
      vscale_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blm_pkg::REG_SAMPLE_COUNT:  cnt_cfg_q  <= cfg_wdata_i[CW-1:0];
        blm_pkg::REG_LEVEL4_THR:    l4_thr_q   <= cfg_wdata_i;
        blm_pkg::REG_LEVEL3_THR:    l3_thr_q   <= cfg_wdata_i;
        blm_pkg::REG_LEVEL2_THR:    l2_thr_q   <= cfg_wdata_i;
        blm_pkg::REG_LEVEL1_THR:    l1_thr_q   <= cfg_wdata_i;
        blm_pkg::REG_WARNING_THR:   warn_thr_q <= cfg_wdata_i;
        blm_pkg::REG_HYSTERESIS:    hyst_q     <= cfg_wdata_i;
        blm_pkg::REG_VOLTAGE_SCALE: vscale_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // payload: captured request, divider, product, output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vin_q   <= s_axis_tdata[blm_pkg::SAMPLE_W-1:0];
      iin_q   <= s_axis_tdata[2*blm_pkg::SAMPLE_W-1:blm_pkg::SAMPLE_W];
      phase_q <= s_axis_tdata[2*blm_pkg::SAMPLE_W+blm_pkg::PHASE_W-1:2*blm_pkg::SAMPLE_W];
    end
    div_q   <= div_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    prod_q  <= PW'(quo_q) * PW'(mul_b);
    odata_q <= odata_d;
  end

  ap_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= blm_pkg::LVL_FOUR)
    else $error("battery level out of range");

  ap_power_only_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !power_q |-> level_q == blm_pkg::LVL_SHUTDOWN)
    else $error("bus power cut outside shutdown");

  ap_buzzer_only_warning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buzz_q |-> level_q == blm_pkg::LVL_WARNING)
    else $error("buzzer on outside warning");

  ap_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == blm_pkg::ST_DIV |-> step_q < blm_pkg::STEP_W'(SW))
    else $error("divider step count overrun");

  ap_second_avg_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == blm_pkg::ST_SAT && sel_q) |=> state_q == blm_pkg::ST_UPD)
    else $error("current average did not lead to update");

endmodule

`default_nettype wire
